### rtl/core/rv32m_mul_div_unit_top_macros.svh
// Assertion macros shared by the multiply / divide unit.
`ifndef RV32M_MUL_DIV_UNIT_TOP_MACROS_SVH
`define RV32M_MUL_DIV_UNIT_TOP_MACROS_SVH

// Implication in the same cycle, checked on every rising clock edge out of reset.
`define MDU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mul/div unit assertion failed");

// Implication into the following cycle.
`define MDU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mul/div unit assertion failed");

`endif

### rtl/core/mdu_pkg.sv
`timescale 1ns / 1ps

package mdu_pkg;

    localparam int XLEN = 32;

    // funct3 operation codes.
    localparam logic [2:0] OP_MUL    = 3'd0;
    localparam logic [2:0] OP_MULH   = 3'd1;
    localparam logic [2:0] OP_MULHSU = 3'd2;
    localparam logic [2:0] OP_MULHU  = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;
    localparam logic [2:0] OP_DIVU   = 3'd5;
    localparam logic [2:0] OP_REM    = 3'd6;
    localparam logic [2:0] OP_REMU   = 3'd7;

    // One pipeline slot. For multiplies rem holds the high product half, quo the
    // low half and dvsr the signed correction; for divides they hold the partial
    // remainder, the shifting dividend / quotient and the divisor magnitude.
    typedef struct packed {
        logic            valid;
        logic [2:0]      mode;
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] dvsr;
        logic            neg_q;
        logic            neg_r;
    } mdu_stage_t;

endpackage

### rtl/core/mdu_prep.sv
`timescale 1ns / 1ps

module mdu_prep
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  logic [2:0]         mode,
    input  logic [31:0]        operand_a,
    input  logic [31:0]        operand_b,
    output mdu_pkg::mdu_stage_t stage_out
);
    import mdu_pkg::*;

    logic            valid0_reg;
    logic [2:0]      mode0_reg;
    logic [XLEN-1:0] a0_reg;
    logic [XLEN-1:0] b0_reg;
    mdu_stage_t      stage1_reg;
    mdu_stage_t      stage1_next;
    logic [2*XLEN-1:0] product;
    logic [XLEN-1:0] corr_a;
    logic [XLEN-1:0] corr_b;
    logic            is_signed_div;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode0_reg <= mode;
            a0_reg    <= operand_a;
            b0_reg    <= operand_b;
        end
    end

    // Unsigned product, signed correction and divide operand set-up.
    always_comb
    begin
        product       = {{XLEN{1'b0}}, a0_reg} * {{XLEN{1'b0}}, b0_reg};
        corr_a        = (a0_reg[XLEN-1] && (mode0_reg == OP_MULH || mode0_reg == OP_MULHSU))
                        ? b0_reg : '0;
        corr_b        = (b0_reg[XLEN-1] && mode0_reg == OP_MULH) ? a0_reg : '0;
        is_signed_div = mode0_reg[2] && !mode0_reg[0];
        stage1_next.valid = valid0_reg;
        stage1_next.mode  = mode0_reg;
        if (!mode0_reg[2])
        begin
            stage1_next.rem   = product[2*XLEN-1:XLEN];
            stage1_next.quo   = product[XLEN-1:0];
            stage1_next.dvsr  = corr_a + corr_b;
            stage1_next.neg_q = 1'b0;
            stage1_next.neg_r = 1'b0;
        end
        else
        begin
            stage1_next.rem   = '0;
            stage1_next.quo   = (is_signed_div && a0_reg[XLEN-1]) ? (~a0_reg + 1'b1) : a0_reg;
            stage1_next.dvsr  = (is_signed_div && b0_reg[XLEN-1]) ? (~b0_reg + 1'b1) : b0_reg;
            // A zero divisor keeps the all-ones quotient; the remainder
            // sign fix then restores the dividend.
            stage1_next.neg_q = is_signed_div && (a0_reg[XLEN-1] ^ b0_reg[XLEN-1])
                                && (b0_reg != '0);
            stage1_next.neg_r = is_signed_div && a0_reg[XLEN-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= '0;
        end
        else if (advance)
        begin
            stage1_reg <= stage1_next;
        end
    end

    assign stage_out = stage1_reg;

endmodule

### rtl/core/mdu_div_step.sv
`timescale 1ns / 1ps

module mdu_div_step
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  mdu_pkg::mdu_stage_t stage_in,
    output mdu_pkg::mdu_stage_t stage_out
);
    import mdu_pkg::*;

    mdu_stage_t    stage_reg;
    mdu_stage_t    stage_next;
    logic [XLEN:0] trial;
    logic [XLEN:0] diff;

    // One restoring division step; multiplies pass through untouched.
    always_comb
    begin
        stage_next = stage_in;
        trial      = {stage_in.rem, stage_in.quo[XLEN-1]};
        diff       = trial - {1'b0, stage_in.dvsr};
        if (stage_in.mode[2])
        begin
            if (!diff[XLEN])
            begin
                stage_next.rem = diff[XLEN-1:0];
                stage_next.quo = {stage_in.quo[XLEN-2:0], 1'b1};
            end
            else
            begin
                stage_next.rem = trial[XLEN-1:0];
                stage_next.quo = {stage_in.quo[XLEN-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

### rtl/core/rv32m_mul_div_unit_top.sv
`timescale 1ns / 1ps
// Pipeline from an accepted input item to its result item: input register,
// multiply stage, 32 divide step stages, output register.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// Reset: rst_n clears all valid bits asynchronously; input and output data are not reset.

module rv32m_mul_div_unit_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // mode[2:0], operand_a[34:3], operand_b[66:35], zero[71:67]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // result_value[31:0]
);
    import mdu_pkg::*;

    `include "rv32m_mul_div_unit_top_macros.svh"

    mdu_stage_t      stage [0:XLEN];
    logic            advance;
    logic            out_valid_reg;
    logic [XLEN-1:0] out_data_reg;
    logic [XLEN-1:0] result_next;
    mdu_stage_t      last;

    // The pipeline moves whenever the output slot is free or being taken.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    mdu_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .mode      (s_tdata[2:0]),
        .operand_a (s_tdata[34:3]),
        .operand_b (s_tdata[66:35]),
        .stage_out (stage[0])
    );

    // One stage per quotient bit.
    for (genvar i = 0; i < XLEN; i++)
    begin : g_step
        mdu_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage_in  (stage[i]),
            .stage_out (stage[i+1])
        );
    end

    assign last = stage[XLEN];

    // Final selection and sign fix-up.
    always_comb
    begin
        if (!last.mode[2])
        begin
            result_next = (last.mode == OP_MUL) ? last.quo : (last.rem - last.dvsr);
        end
        else if (last.mode[1])
        begin
            result_next = last.neg_r ? (~last.rem + 1'b1) : last.rem;
        end
        else
        begin
            result_next = last.neg_q ? (~last.quo + 1'b1) : last.quo;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A stalled result holds the input side.
    `MDU_ASSERT_SAME(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    // An empty output slot never refuses an item.
    `MDU_ASSERT_SAME(a_empty_accepts, !m_tvalid, s_tready)
    // A finished item that moves on lands in the output register.
    `MDU_ASSERT_NEXT(a_last_to_out, last.valid && advance, m_tvalid)

endmodule
